/* rtl/olist_pkg.sv */
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and codes for the ordered list engine: command, status and
// action codes, cell operations, cell compare flags and controller states.
// ----------------------------------------------------------------------------
package olist_pkg;

  typedef enum logic [3:0] {
    CMD_APPEND    = 4'd0,
    CMD_PREPEND   = 4'd1,
    CMD_INSERT    = 4'd2,
    CMD_SORTED    = 4'd3,
    CMD_DEL_FIRST = 4'd4,
    CMD_DEL_LAST  = 4'd5,
    CMD_DEL_VALUE = 4'd6,
    CMD_SEARCH    = 4'd7,
    CMD_DISPLAY   = 4'd8
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_RANGE     = 3'd4
  } status_t;

  // What one cell loads on the next edge.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_LEFT,
    OP_RIGHT
  } cell_op_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

  // Effect of one decoded command on the list.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_INS,
    ACT_DEL,
    ACT_DROP_LAST,
    ACT_DISP
  } act_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DISP
  } fsm_t;

endpackage

/* rtl/olist_cmd_if.sv */
// ----------------------------------------------------------------------------
// olist_cmd_if
// Command channel: valid/ready handshake with command, value and position.
// ----------------------------------------------------------------------------
interface olist_cmd_if #(
  parameter int DATA_WIDTH = 32,
  parameter int POS_WIDTH  = 5
);
  logic                         valid;
  logic                         ready;
  logic [3:0]                   cmd;
  logic signed [DATA_WIDTH-1:0] value;
  logic [POS_WIDTH-1:0]         position;

  modport source (output valid, cmd, value, position, input ready);
  modport sink   (input valid, cmd, value, position, output ready);
endinterface

/* rtl/olist_res_if.sv */
// ----------------------------------------------------------------------------
// olist_res_if
// Result channel: valid/ready handshake with status, entry and count fields.
// ----------------------------------------------------------------------------
interface olist_res_if #(
  parameter int DATA_WIDTH = 32,
  parameter int POS_WIDTH  = 5
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   status;
  logic [POS_WIDTH-1:0]         entry_position;
  logic signed [DATA_WIDTH-1:0] entry_data;
  logic [POS_WIDTH-1:0]         entry_count;
  logic                         last;

  modport source (output valid, status, entry_position, entry_data, entry_count, last,
                  input ready);
  modport sink   (input valid, status, entry_position, entry_data, entry_count, last,
                  output ready);
endinterface

/* rtl/olist_cell.sv */
// ----------------------------------------------------------------------------
// olist_cell
// One list slot: holds a word, compares it against the command word and
// loads the command word or a neighbor's word as the controller directs.
// ----------------------------------------------------------------------------
module olist_cell import olist_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  cell_op_t                     op,
  input  logic signed [DATA_WIDTH-1:0] word,
  input  logic signed [DATA_WIDTH-1:0] left,
  input  logic signed [DATA_WIDTH-1:0] right,
  output logic signed [DATA_WIDTH-1:0] data,
  output cell_flags_t                  flags
);

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD:  data <= word;
      OP_LEFT:  data <= left;
      OP_RIGHT: data <= right;
      default:  data <= data;
    endcase
  end

  assign flags.lt = data < word;
  assign flags.eq = data == word;

endmodule

/* rtl/ordered_list_engine.sv */
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded ordered list of signed words kept in a ring of compare/shift cells.
// ----------------------------------------------------------------------------
// A command is accepted in the idle state and executed in the exec state once
// the output register is free: all cells compare against the command word at
// once and shift by one place. Display rotates the whole ring through cell 0,
// one cell per cycle while the output register is free, and streams one result
// per entry with last set on the final one; other commands give one result.
// The next command is accepted while a result still waits in the output
// register; execution waits only when that register is still full.
// ----------------------------------------------------------------------------
module ordered_list_engine import olist_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  olist_cmd_if.sink   command,
  olist_res_if.source result
);

  localparam int CW = $clog2(CAPACITY + 1);

  fsm_t                         state, state_next;
  logic [3:0]                   cur_cmd;
  logic signed [DATA_WIDTH-1:0] word;
  logic [CW-1:0]                pos;
  logic [CW-1:0]                count, count_next;
  logic [CW-1:0]                k;
  logic                         rvalid;
  logic                         out_free;
  logic                         step;
  logic                         load_res;

  logic [2:0]                   r_status, n_status;
  logic [CW-1:0]                r_pos, n_pos;
  logic signed [DATA_WIDTH-1:0] r_data, n_data;
  logic [CW-1:0]                r_count;
  logic                         r_last, n_last;

  cell_op_t                     ops   [CAPACITY];
  logic signed [DATA_WIDTH-1:0] cdata [CAPACITY];
  cell_flags_t                  flags [CAPACITY];
  logic [CAPACITY-1:0]          lt_vec, eq_vec;

  act_t                         act;
  logic [CW-1:0]                idx;
  logic [2:0]                   stat;
  logic [CW-1:0]                found_pos;
  logic [CW:0]                  sort_hit, match_hit;
  logic                         full, empty;

  // lowest set bit: {hit, index}
  function automatic logic [CW:0] first_set(input logic [CAPACITY-1:0] v);
    logic [CW:0] r;
    r = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (v[i]) r = {1'b1, CW'(i)};
    end
    return r;
  endfunction

  // Ring of cells; left of cell 0 and right of the last cell wrap around.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    olist_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk   (clk),
      .op    (ops[i]),
      .word  (word),
      .left  (cdata[(i + CAPACITY - 1) % CAPACITY]),
      .right (cdata[(i + 1) % CAPACITY]),
      .data  (cdata[i]),
      .flags (flags[i])
    );
    assign lt_vec[i] = flags[i].lt && (CW'(i) < count);
    assign eq_vec[i] = flags[i].eq && (CW'(i) < count);
  end

  assign full      = count == CW'(CAPACITY);
  assign empty     = count == '0;
  assign sort_hit  = first_set(~lt_vec);
  assign match_hit = first_set(eq_vec);
  assign out_free  = !rvalid || result.ready;
  assign step      = out_free || !(k < count);

  // Decode the held command against the current list.
  always_comb begin
    act       = ACT_NONE;
    idx       = '0;
    stat      = STAT_OK;
    found_pos = '0;
    case (cur_cmd)
      CMD_APPEND, CMD_PREPEND, CMD_INSERT, CMD_SORTED: begin
        if (full) begin
          stat = STAT_FULL;
        end else if (cur_cmd == CMD_APPEND) begin
          act = ACT_INS;
          idx = count;
        end else if (cur_cmd == CMD_PREPEND) begin
          act = ACT_INS;
        end else if (cur_cmd == CMD_INSERT) begin
          if (empty) begin
            act = ACT_INS;
          end else if (pos > count) begin
            stat = STAT_RANGE;
          end else begin
            act = ACT_INS;
            idx = pos;
          end
        end else begin
          act = ACT_INS;
          idx = sort_hit[CW-1:0];
        end
      end
      CMD_DEL_FIRST: begin
        if (empty) stat = STAT_EMPTY;
        else act = ACT_DEL;
      end
      CMD_DEL_LAST: begin
        if (empty) stat = STAT_EMPTY;
        else act = ACT_DROP_LAST;
      end
      CMD_DEL_VALUE, CMD_SEARCH: begin
        if (empty) begin
          stat = STAT_EMPTY;
        end else if (!match_hit[CW]) begin
          stat = STAT_NOT_FOUND;
        end else if (cur_cmd == CMD_DEL_VALUE) begin
          act = ACT_DEL;
          idx = match_hit[CW-1:0];
        end else begin
          found_pos = match_hit[CW-1:0] + CW'(1);
        end
      end
      CMD_DISPLAY: begin
        if (empty) stat = STAT_EMPTY;
        else act = ACT_DISP;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (command.valid) state_next = S_EXEC;
      S_EXEC: begin
        if (out_free) state_next = (act == ACT_DISP) ? S_DISP : S_IDLE;
      end
      S_DISP: if (step && k == CW'(CAPACITY - 1)) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: cell operations, count update and result load
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) ops[i] = OP_HOLD;
    count_next = count;
    load_res   = 1'b0;
    n_status   = STAT_OK;
    n_pos      = '0;
    n_data     = '0;
    n_last     = 1'b1;
    case (state)
      S_EXEC: begin
        if (out_free) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (act == ACT_INS) begin
              if (CW'(i) == idx) ops[i] = OP_LOAD;
              else if (CW'(i) > idx) ops[i] = OP_LEFT;
            end else if (act == ACT_DEL) begin
              if (CW'(i) >= idx) ops[i] = OP_RIGHT;
            end
          end
          if (act == ACT_INS) count_next = count + CW'(1);
          else if (act == ACT_DEL || act == ACT_DROP_LAST) count_next = count - CW'(1);
          load_res = act != ACT_DISP;
          n_status = stat;
          n_pos    = found_pos;
        end
      end
      S_DISP: begin
        if (step) begin
          for (int i = 0; i < CAPACITY; i++) ops[i] = OP_RIGHT;
          if (k < count) begin
            load_res = 1'b1;
            n_pos    = k + CW'(1);
            n_data   = cdata[0];
            n_last   = (k + CW'(1)) == count;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      k      <= '0;
      rvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state != S_DISP) k <= '0;
      else if (step) k <= k + CW'(1);
      if (load_res) rvalid <= 1'b1;
      else if (result.ready) rvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (command.valid && command.ready) begin
      cur_cmd <= command.cmd;
      word    <= command.value;
      pos     <= command.position;
    end
    if (load_res) begin
      r_status <= n_status;
      r_pos    <= n_pos;
      r_data   <= n_data;
      r_count  <= count_next;
      r_last   <= n_last;
    end
  end

  assign command.ready         = state == S_IDLE;
  assign result.valid          = rvalid;
  assign result.status         = r_status;
  assign result.entry_position = r_pos;
  assign result.entry_data     = r_data;
  assign result.entry_count    = r_count;
  assign result.last           = r_last;

endmodule

/* test/ordered_list_engine_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_list_engine_tb
// Self-checking bench for the ordered list engine. A directed table covers
// empty-list errors, position limits, extremes of the data word, a full list
// and every command. A random run of fill and drain phases follows. A
// shadow list predicts every result but those of typed table rows, and results
// are compared in order as they leave the block. Both channels idle at random,
// and the result side holds off once so the block backs up.
// ----------------------------------------------------------------------------
module ordered_list_engine_tb;
  import olist_pkg::*;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int RAND_ITEMS = 260;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 10;
  localparam logic [3:0] CMD_SPARE_LO = 4'd9;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [2:0]        status;
    logic [4:0]        position;
    logic signed [31:0] data;
    logic [4:0]        count;
    logic              last_flag;
  } res_item_t;

  typedef struct {
    logic [3:0]         cmd;
    logic signed [31:0] value;
    logic [4:0]         position;
    int                 reps;
    bit                 typed;     // expected status and count given below
    logic [2:0]         status;
    logic [4:0]         count;
  } stim_row_t;

  logic clk;
  logic rst;

  olist_cmd_if #(.DATA_WIDTH(DATA_WIDTH), .POS_WIDTH(5)) cmd_ch ();
  olist_res_if #(.DATA_WIDTH(DATA_WIDTH), .POS_WIDTH(5)) res_ch ();

  ordered_list_engine #(
    .CAPACITY(CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .command(cmd_ch),
    .result(res_ch)
  );

  // shadow list
  logic signed [31:0] list_mem [CAPACITY];
  int                 list_cnt;

  res_item_t step_results[$];
  res_item_t pending_results[$];

  int mismatch_cnt;
  int items_sent;
  int results_checked;
  int full_hits;
  int displays_sent;
  bit no_idle;
  bit hold_req;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #1_000_000;
    $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
    $display("[ordered_list_engine] ERROR");
    $finish;
  end

  function automatic void list_put(int idx, logic signed [31:0] w);
    for (int i = list_cnt; i > idx; i--) list_mem[i] = list_mem[i-1];
    list_mem[idx] = w;
    list_cnt++;
  endfunction

  function automatic void list_take(int idx);
    for (int i = idx; i + 1 < list_cnt; i++) list_mem[i] = list_mem[i+1];
    list_cnt--;
  endfunction

  // Applies one command to the shadow list and leaves its results in step_results.
  function automatic void apply_list_cmd(logic [3:0] c, logic signed [31:0] v,
                                         logic [4:0] p);
    status_t st;
    int      found;
    int      i;
    st = STAT_OK;
    found = 0;
    step_results.delete();
    case (c)
      CMD_APPEND, CMD_PREPEND, CMD_INSERT, CMD_SORTED: begin
        if (list_cnt >= CAPACITY) begin
          st = STAT_FULL;
        end else if (c == CMD_APPEND) begin
          list_put(list_cnt, v);
        end else if (c == CMD_PREPEND) begin
          list_put(0, v);
        end else if (c == CMD_INSERT) begin
          if (list_cnt == 0) list_put(0, v);
          else if (int'(p) > list_cnt) st = STAT_RANGE;
          else list_put(int'(p), v);
        end else begin
          i = 0;
          while (i < list_cnt && list_mem[i] < v) i++;
          list_put(i, v);
        end
      end
      CMD_DEL_FIRST: begin
        if (list_cnt == 0) st = STAT_EMPTY;
        else list_take(0);
      end
      CMD_DEL_LAST: begin
        if (list_cnt == 0) st = STAT_EMPTY;
        else list_cnt--;
      end
      CMD_DEL_VALUE, CMD_SEARCH: begin
        if (list_cnt == 0) begin
          st = STAT_EMPTY;
        end else begin
          i = 0;
          while (i < list_cnt && list_mem[i] != v) i++;
          if (i == list_cnt) st = STAT_NOT_FOUND;
          else if (c == CMD_DEL_VALUE) list_take(i);
          else found = i + 1;
        end
      end
      CMD_DISPLAY: begin
        if (list_cnt == 0) begin
          step_results.push_back('{STAT_EMPTY, 5'd0, 32'sd0, 5'd0, 1'b1});
        end else begin
          for (int k = 0; k < list_cnt; k++)
            step_results.push_back('{STAT_OK, 5'(k + 1), list_mem[k], 5'(list_cnt),
                                     (k + 1 == list_cnt)});
        end
        return;
      end
      default: ;  // spare codes leave the list alone
    endcase
    step_results.push_back('{st, 5'(found), 32'sd0, 5'(list_cnt), 1'b1});
  endfunction

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3: return int'($urandom_range(15)) - 8;  // narrow range gives duplicates
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    if (list_cnt > 0 && $urandom_range(2) != 0)
      return list_mem[$urandom_range(list_cnt - 1)];
    return rand_word();
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(logic [3:0] c, logic signed [31:0] v, logic [4:0] p,
                           bit typed, logic [2:0] st, logic [4:0] cnt);
    if (!no_idle && !hold_req && $urandom_range(99) < 14) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.cmd      <= c;
    cmd_ch.value    <= v;
    cmd_ch.position <= p;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    if (c <= CMD_SORTED && list_cnt == CAPACITY) full_hits++;
    if (c == CMD_DISPLAY) displays_sent++;
    apply_list_cmd(c, v, p);
    if (typed) begin
      pending_results.push_back('{st, 5'd0, 32'sd0, cnt, 1'b1});
    end else begin
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_item_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result, expected none, actual status %0d count %0d",
                 $time, res_ch.status, res_ch.entry_count);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(res_ch.status));
        check_field("entry_position", 32'(want.position), 32'(res_ch.entry_position));
        check_field("entry_data", want.data, res_ch.entry_data);
        check_field("entry_count", 32'(want.count), 32'(res_ch.entry_count));
        check_field("last", 32'(want.last_flag), 32'(res_ch.last));
        results_checked++;
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        res_ch.ready <= no_idle || ($urandom_range(99) >= 14);
      end
    end
  end

  initial begin
    stim_row_t   dir_tab [28];
    int          n_real;
    int          r;
    bit          fill_mode;
    bit          hold_fired;
    logic [3:0]  c;
    logic signed [31:0] v;
    logic [4:0]  p;

    rst             = 1'b1;
    cmd_ch.valid    = 1'b0;
    cmd_ch.cmd      = CMD_APPEND;
    cmd_ch.value    = '0;
    cmd_ch.position = '0;
    list_cnt        = 0;
    mismatch_cnt    = 0;
    items_sent      = 0;
    results_checked = 0;
    full_hits       = 0;
    displays_sent   = 0;
    no_idle         = 1'b0;
    hold_req        = 1'b0;
    fill_mode       = 1'b1;
    hold_fired      = 1'b0;
    n_real          = 0;

    dir_tab = '{
      '{CMD_DISPLAY,   32'sd0,            5'd0,  1,  1'b1, STAT_EMPTY,     5'd0},
      '{CMD_DEL_FIRST, 32'sd0,            5'd0,  1,  1'b1, STAT_EMPTY,     5'd0},
      '{CMD_DEL_LAST,  32'sd0,            5'd0,  1,  1'b1, STAT_EMPTY,     5'd0},
      '{CMD_DEL_VALUE, 32'sd3,            5'd0,  1,  1'b1, STAT_EMPTY,     5'd0},
      '{CMD_SEARCH,    32'sd3,            5'd0,  1,  1'b1, STAT_EMPTY,     5'd0},
      // empty list takes any position
      '{CMD_INSERT,    32'sd42,           5'd16, 1,  1'b1, STAT_OK,        5'd1},
      '{CMD_APPEND,    32'sh7fff_ffff,    5'd0,  1,  1'b1, STAT_OK,        5'd2},
      '{CMD_PREPEND,   32'sh8000_0000,    5'd0,  1,  1'b1, STAT_OK,        5'd3},
      '{CMD_INSERT,    32'sd9,            5'd4,  1,  1'b1, STAT_RANGE,     5'd3},
      '{CMD_INSERT,    32'sd5,            5'd3,  1,  1'b1, STAT_OK,        5'd4},
      '{CMD_INSERT,    -32'sd1,           5'd0,  1,  1'b1, STAT_OK,        5'd5},
      '{CMD_SORTED,    32'sd0,            5'd0,  1,  1'b0, STAT_OK,        5'd0},
      // equal value goes ahead of the existing max
      '{CMD_SORTED,    32'sh7fff_ffff,    5'd0,  1,  1'b0, STAT_OK,        5'd0},
      '{CMD_SEARCH,    32'sd5,            5'd0,  1,  1'b0, STAT_OK,        5'd0},
      '{CMD_SEARCH,    32'sd12345,        5'd0,  1,  1'b1, STAT_NOT_FOUND, 5'd7},
      '{CMD_DEL_VALUE, -32'sd1,           5'd0,  1,  1'b1, STAT_OK,        5'd6},
      '{CMD_DISPLAY,   32'sd0,            5'd0,  1,  1'b0, STAT_OK,        5'd0},
      '{CMD_SPARE_LO,  32'sd1,            5'd1,  1,  1'b1, STAT_OK,        5'd6},
      '{CMD_SPARE_HI,  -32'sd1,           5'd16, 1,  1'b1, STAT_OK,        5'd6},
      '{CMD_APPEND,    32'sh5555_5555,    5'd0,  10, 1'b0, STAT_OK,        5'd0},
      '{CMD_APPEND,    32'sd1,            5'd0,  1,  1'b1, STAT_FULL,      5'd16},
      '{CMD_PREPEND,   32'sd1,            5'd0,  1,  1'b1, STAT_FULL,      5'd16},
      '{CMD_INSERT,    32'sd1,            5'd16, 1,  1'b1, STAT_FULL,      5'd16},
      '{CMD_SORTED,    32'sd1,            5'd0,  1,  1'b1, STAT_FULL,      5'd16},
      '{CMD_DISPLAY,   32'sd0,            5'd0,  1,  1'b0, STAT_OK,        5'd0},
      '{CMD_DEL_FIRST, 32'sd0,            5'd0,  1,  1'b1, STAT_OK,        5'd15},
      '{CMD_DEL_LAST,  32'sd0,            5'd0,  1,  1'b1, STAT_OK,        5'd14},
      '{CMD_DEL_VALUE, 32'sh2aaa_aaaa,    5'd0,  1,  1'b1, STAT_NOT_FOUND, 5'd14}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      repeat (dir_tab[i].reps)
        send_item(dir_tab[i].cmd, dir_tab[i].value, dir_tab[i].position,
                  dir_tab[i].typed, dir_tab[i].status, dir_tab[i].count);
    end

    // random part: fill and drain phases so the full and empty corners recur
    while (n_real < RAND_ITEMS) begin
      no_idle = (n_real >= 100 && n_real < 160);
      if (n_real >= 220 && !hold_fired) begin
        hold_fired = 1'b1;
        hold_req = 1'b1;
      end
      if (fill_mode && list_cnt == CAPACITY && $urandom_range(3) == 0) fill_mode = 1'b0;
      if (!fill_mode && list_cnt == 0 && $urandom_range(3) == 0) fill_mode = 1'b1;

      r = $urandom_range(99);
      if (!fill_mode) r = (r < 20) ? r * 3 : ((r < 95) ? r : r);
      v = rand_word();
      p = 5'($urandom_range(0, list_cnt));
      if (r >= 95) begin
        // noise: spare codes and out-of-range positions
        if ($urandom_range(1)) begin
          c = 4'($urandom_range(int'(CMD_SPARE_LO), int'(CMD_SPARE_HI)));
        end else begin
          c = CMD_INSERT;
        end
        p = 5'($urandom_range(0, CAPACITY));
      end else if (fill_mode ? (r < 60) : (r < 20)) begin
        case ($urandom_range(3))
          0: c = CMD_APPEND;
          1: c = CMD_PREPEND;
          2: c = CMD_INSERT;
          default: c = CMD_SORTED;
        endcase
        if (c == CMD_SORTED) v = pick_value();
        if ($urandom_range(7) == 0) p = 5'($urandom_range(0, CAPACITY));
      end else if (fill_mode ? (r < 75) : (r < 35)) begin
        c = CMD_SEARCH;
        v = pick_value();
      end else if (fill_mode ? (r < 85) : (r < 45)) begin
        c = CMD_DISPLAY;
      end else begin
        case ($urandom_range(2))
          0: c = CMD_DEL_FIRST;
          1: c = CMD_DEL_LAST;
          default: c = CMD_DEL_VALUE;
        endcase
        v = pick_value();
      end
      send_item(c, v, p, 1'b0, STAT_OK, 5'd0);
      if (c <= CMD_DISPLAY) n_real++;
    end
    cmd_ch.valid <= 1'b0;
    no_idle = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands (%0d displays, %0d adds on a full list), %0d results checked",
             items_sent, displays_sent, full_hits, results_checked);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("[ordered_list_engine] OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatch_cnt,
               pending_results.size());
      $display("[ordered_list_engine] ERROR");
    end
    $finish;
  end

endmodule

/* ordered_list_engine.f */
rtl/olist_pkg.sv
rtl/olist_cmd_if.sv
rtl/olist_res_if.sv
rtl/olist_cell.sv
rtl/ordered_list_engine.sv
test/ordered_list_engine_tb.sv
